@@ src/wmm_pkg.sv @@
// shared types, character codes and helpers for the wildcard mask matcher
package wmm_pkg;

   localparam logic [7:0] CH_NUL    = 8'h00;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_QUEST  = 8'h3F;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_Z = 8'h5A;
   localparam logic [7:0] CASE_OFFSET = 8'h20;

   // control from the loader to the walk sequencer
   typedef struct packed {
      logic start;
      logic ovf;
      logic rsp_free;
   } walk_ctl_type;

   // status from the walk sequencer back to the loader
   typedef struct packed {
      logic idle;
      logic done;
      logic hit;
   } walk_sts_type;

   // ascii upper case letters fold to lower case, everything else as is
   function automatic logic [7:0] fold_char(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
         r = c + CASE_OFFSET;
      end
      return r;
   endfunction

endpackage

@@ src/wmm_req_if.sv @@
// request channel carrying one mask or name byte per beat
interface wmm_req_if;
   logic       valid;
   logic       ready;
   logic       operation;
   logic [7:0] char_code;
   logic       empty_req;
   logic       last;

   modport source (output valid, operation, char_code, empty_req, last, input ready);
   modport sink   (input valid, operation, char_code, empty_req, last, output ready);
endinterface

@@ src/wmm_rsp_if.sv @@
// response channel carrying one match result per beat
interface wmm_rsp_if;
   logic valid;
   logic ready;
   logic matched;
   logic overflow;

   modport source (output valid, matched, overflow, input ready);
   modport sink   (input valid, matched, overflow, output ready);
endinterface

@@ src/wmm_ram.sv @@
// generic simple dual port ram, one write and one registered read port
module wmm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end

endmodule

@@ src/wmm_walker.sv @@
// backtracking glob walk sequencer over the mask and name memories
module wmm_walker #(
   parameter int MASK_CHARS = 64,
   parameter int NAME_CHARS = 64,
   localparam int MLW = $clog2(MASK_CHARS + 1),
   localparam int NLW = $clog2(NAME_CHARS + 1),
   localparam int MPW = MLW + 1,
   localparam int NPW = NLW + 1
) (
   input  logic                 clock,
   input  logic                 reset,
   input  wmm_pkg::walk_ctl_type ctl,
   output wmm_pkg::walk_sts_type sts,
   input  logic [MLW-1:0]       mask_len,
   input  logic [NLW-1:0]       name_len,
   output logic [MPW-1:0]       mask_rd_addr,
   output logic [NPW-1:0]       name_rd_addr,
   input  logic [7:0]           mask_rd_data,
   input  logic [7:0]           name_rd_data
);
   import wmm_pkg::*;

   typedef enum logic [7:0] {
      S_IDLE  = 8'b0000_0001,
      S_INIT  = 8'b0000_0010,
      S_HEAD  = 8'b0000_0100,
      S_CMP   = 8'b0000_1000,
      S_ESC   = 8'b0001_0000,
      S_BACK  = 8'b0010_0000,
      S_BACK2 = 8'b0100_0000,
      S_DONE  = 8'b1000_0000
   } walk_state_type;

   walk_state_type state_ff, state_in;
   logic [MPW-1:0] m_ff, m_in, mretry_ff, mretry_in;
   logic [NPW-1:0] n_ff, n_in, nretry_ff, nretry_in;
   logic           wild_ff, wild_in;
   logic           star_run_ff, star_run_in;
   logic           hit_ff, hit_in;
   logic           mok_ff, nok_ff;
   logic [7:0]     mv, nv;
   logic           alt_en;
   logic [MPW-1:0] alt_addr;
   logic           cmp_en, cmp_lit;
   logic [7:0]     cmp_c;
   logic [MPW-1:0] cmp_m;
   logic           done;

   // reads past the length come back as end of string
   assign mv = mok_ff ? mask_rd_data : CH_NUL;
   assign nv = nok_ff ? name_rd_data : CH_NUL;

   always_comb begin
      state_in    = state_ff;
      m_in        = m_ff;
      n_in        = n_ff;
      mretry_in   = mretry_ff;
      nretry_in   = nretry_ff;
      wild_in     = wild_ff;
      star_run_in = star_run_ff;
      hit_in      = hit_ff;
      alt_en      = 1'b0;
      alt_addr    = m_ff;
      cmp_en      = 1'b0;
      cmp_c       = mv;
      cmp_lit     = 1'b0;
      cmp_m       = m_ff;
      done        = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (ctl.start) begin
               state_in = S_INIT;
            end
         end
         S_INIT: begin
            m_in        = '0;
            n_in        = '0;
            mretry_in   = '0;
            nretry_in   = '0;
            wild_in     = 1'b0;
            star_run_in = 1'b0;
            hit_in      = 1'b0;
            state_in    = ctl.ovf ? S_DONE : S_HEAD;
         end
         S_HEAD: begin
            if (mv == CH_STAR) begin
               m_in        = m_ff + MPW'(1);
               star_run_in = 1'b1;
            end else begin
               star_run_in = 1'b0;
               if (star_run_ff) begin
                  wild_in   = 1'b1;
                  mretry_in = m_ff;
                  nretry_in = n_ff;
               end
               if (mv == CH_NUL) begin
                  if (nv == CH_NUL) begin
                     hit_in   = 1'b1;
                     state_in = S_DONE;
                  end else if (m_ff == '0) begin
                     hit_in   = 1'b0;
                     state_in = S_DONE;
                  end else begin
                     m_in     = m_ff - MPW'(1);
                     state_in = S_BACK;
                  end
               end else if (nv == CH_NUL) begin
                  // name used up against a plain mask character
                  hit_in   = 1'b0;
                  state_in = S_DONE;
               end else begin
                  state_in = S_CMP;
               end
            end
         end
         S_CMP: begin
            if (mv == CH_BSLASH) begin
               alt_en   = 1'b1;
               alt_addr = m_ff + MPW'(1);
               state_in = S_ESC;
            end else begin
               cmp_en = 1'b1;
            end
         end
         S_ESC: begin
            cmp_en = 1'b1;
            if (mv == CH_STAR || mv == CH_QUEST) begin
               cmp_lit = 1'b1;
               cmp_m   = m_ff + MPW'(1);
            end else begin
               cmp_c = CH_BSLASH;
            end
         end
         S_BACK: begin
            if (m_ff != '0 && mv == CH_QUEST) begin
               m_in = m_ff - MPW'(1);
            end else if (m_ff != '0 && mv == CH_STAR) begin
               alt_en   = 1'b1;
               alt_addr = m_ff - MPW'(1);
               state_in = S_BACK2;
            end else if (!wild_ff) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               m_in      = mretry_ff;
               nretry_in = nretry_ff + NPW'(1);
               n_in      = nretry_ff + NPW'(1);
               state_in  = S_CMP;
            end
         end
         S_BACK2: begin
            // star before a trailing question run: unescaped means a match
            if (mv != CH_BSLASH) begin
               hit_in   = 1'b1;
               state_in = S_DONE;
            end else if (!wild_ff) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               m_in      = mretry_ff;
               nretry_in = nretry_ff + NPW'(1);
               n_in      = nretry_ff + NPW'(1);
               state_in  = S_CMP;
            end
         end
         S_DONE: begin
            if (ctl.rsp_free) begin
               done     = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (cmp_en) begin
         if (fold_char(cmp_c) != fold_char(nv) && (cmp_c != CH_QUEST || cmp_lit)) begin
            if (!wild_ff) begin
               hit_in   = 1'b0;
               state_in = S_DONE;
            end else begin
               m_in      = mretry_ff;
               nretry_in = nretry_ff + NPW'(1);
               n_in      = nretry_ff + NPW'(1);
               state_in  = S_HEAD;
            end
         end else begin
            m_in     = (cmp_c != CH_NUL) ? cmp_m + MPW'(1) : cmp_m;
            n_in     = (nv != CH_NUL) ? n_ff + NPW'(1) : n_ff;
            state_in = S_HEAD;
         end
      end
   end

   assign mask_rd_addr = alt_en ? alt_addr : m_in;
   assign name_rd_addr = n_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      m_ff        <= m_in;
      n_ff        <= n_in;
      mretry_ff   <= mretry_in;
      nretry_ff   <= nretry_in;
      wild_ff     <= wild_in;
      star_run_ff <= star_run_in;
      hit_ff      <= hit_in;
      mok_ff      <= mask_rd_addr < {1'b0, mask_len};
      nok_ff      <= name_rd_addr < {1'b0, name_len};
   end

   assign sts.idle = (state_ff == S_IDLE);
   assign sts.done = done;
   assign sts.hit  = hit_ff;

endmodule

@@ src/wildcard_mask_matcher.sv @@
// top level of the wildcard mask matcher: byte loader, string memories, walk, result stage
//
//   channel | dir | beat carries                              | accepted when
//   --------+-----+-------------------------------------------+---------------------------
//   req_if  | in  | operation, char_code, empty_req, last      | valid && ready
//   rsp_if  | out | matched, overflow                          | valid && ready
//
// back-to-back loading runs at one byte a cycle while the walk sequencer is idle
// the name's last beat starts the walk: ready stays low until the result is in the output
// register, and each backtrack restarts the steps from the retry point, so the walk grows
// with mask length times name length
// every walk step waits on the registered read of the mask and name memories
// reset clears lengths, overflow flag, walk state and the output valid flag; memories are not cleared
// a result waiting on rsp_if does not stop mask bytes; only the end of the next walk waits for it
module wildcard_mask_matcher #(
   parameter int MASK_CHARS = 64,
   parameter int NAME_CHARS = 64
) (
   input  logic          clock,
   input  logic          reset,
   wmm_req_if.sink       req_if,
   wmm_rsp_if.source     rsp_if
);
   import wmm_pkg::*;

   localparam int MLW = $clog2(MASK_CHARS + 1);
   localparam int NLW = $clog2(NAME_CHARS + 1);
   localparam int MPW = MLW + 1;
   localparam int NPW = NLW + 1;
   localparam int MAW = (MASK_CHARS > 1) ? $clog2(MASK_CHARS) : 1;
   localparam int NAW = (NAME_CHARS > 1) ? $clog2(NAME_CHARS) : 1;

   // string lengths and the overflow flag
   logic [MLW-1:0] mlen_ff, mlen_in;
   logic [NLW-1:0] nlen_ff, nlen_in;
   logic           ovf_ff, ovf_in;

   // output register
   logic rsp_valid_ff, rsp_valid_in;
   logic rsp_matched_ff, rsp_matched_in;
   logic rsp_overflow_ff, rsp_overflow_in;

   logic           accept;
   logic           mask_full, name_full;
   logic           mask_wr, name_wr;
   logic [MPW-1:0] mask_rd_addr;
   logic [NPW-1:0] name_rd_addr;
   logic [7:0]     mask_rd_data, name_rd_data;
   walk_ctl_type   ctl;
   walk_sts_type   sts;

   // input side: take a beat only while the walk sequencer is idle
   assign req_if.ready = sts.idle;
   assign accept       = req_if.valid && req_if.ready;

   assign mask_full = (mlen_ff == MLW'(MASK_CHARS));
   assign name_full = (nlen_ff == NLW'(NAME_CHARS));

   // a beat with a character appends it unless the string buffer is full
   assign mask_wr = accept && !req_if.operation && !req_if.empty_req && !mask_full;
   assign name_wr = accept && req_if.operation && !req_if.empty_req && !name_full;

   always_comb begin
      mlen_in = mlen_ff;
      nlen_in = nlen_ff;
      ovf_in  = ovf_ff;
      if (mask_wr) begin
         mlen_in = mlen_ff + MLW'(1);
      end
      if (name_wr) begin
         nlen_in = nlen_ff + NLW'(1);
      end
      if (accept && !req_if.empty_req &&
          ((req_if.operation && name_full) || (!req_if.operation && mask_full))) begin
         ovf_in = 1'b1;
      end
      // result loaded into the output register: both strings and the overflow flag start afresh
      if (sts.done) begin
         mlen_in = '0;
         nlen_in = '0;
         ovf_in  = 1'b0;
      end
   end

   // string memories
   wmm_ram #(
      .WIDTH (8),
      .DEPTH (MASK_CHARS)
   ) u_mask_ram (
      .clock   (clock),
      .wr_en   (mask_wr),
      .wr_addr (mlen_ff[MAW-1:0]),
      .wr_data (req_if.char_code),
      .rd_addr (mask_rd_addr[MAW-1:0]),
      .rd_data (mask_rd_data)
   );

   wmm_ram #(
      .WIDTH (8),
      .DEPTH (NAME_CHARS)
   ) u_name_ram (
      .clock   (clock),
      .wr_en   (name_wr),
      .wr_addr (nlen_ff[NAW-1:0]),
      .wr_data (req_if.char_code),
      .rd_addr (name_rd_addr[NAW-1:0]),
      .rd_data (name_rd_data)
   );

   // walk sequencer, started by the name's last beat
   assign ctl.start    = accept && req_if.operation && req_if.last;
   assign ctl.ovf      = ovf_ff;
   assign ctl.rsp_free = !rsp_valid_ff || rsp_if.ready;

   wmm_walker #(
      .MASK_CHARS (MASK_CHARS),
      .NAME_CHARS (NAME_CHARS)
   ) u_walker (
      .clock        (clock),
      .reset        (reset),
      .ctl          (ctl),
      .sts          (sts),
      .mask_len     (mlen_ff),
      .name_len     (nlen_ff),
      .mask_rd_addr (mask_rd_addr),
      .name_rd_addr (name_rd_addr),
      .mask_rd_data (mask_rd_data),
      .name_rd_data (name_rd_data)
   );

   // output register: an overflow forces no match
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_matched_in  = rsp_matched_ff;
      rsp_overflow_in = rsp_overflow_ff;
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (sts.done) begin
         rsp_valid_in    = 1'b1;
         rsp_matched_in  = sts.hit && !ovf_ff;
         rsp_overflow_in = ovf_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mlen_ff      <= '0;
         nlen_ff      <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mlen_ff      <= mlen_in;
         nlen_ff      <= nlen_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_matched_ff  <= rsp_matched_in;
      rsp_overflow_ff <= rsp_overflow_in;
   end

   assign rsp_if.valid    = rsp_valid_ff;
   assign rsp_if.matched  = rsp_matched_ff;
   assign rsp_if.overflow = rsp_overflow_ff;

   // a finished walk always lands in the output register
   a_done_loads_rsp: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> rsp_valid_ff)
      else $error("finished walk did not produce a response beat");

   // a finished walk leaves empty strings behind
   a_done_clears: assert property (@(posedge clock) disable iff (reset)
      sts.done |=> (mlen_ff == '0 && nlen_ff == '0 && !ovf_ff))
      else $error("strings not cleared after a result");

   // an overflowed result never reports a match
   a_ovf_no_match: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_matched_ff && rsp_overflow_ff))
      else $error("overflow result reported as a match");

   // lengths never pass their buffers
   a_len_bound: assert property (@(posedge clock) disable iff (reset)
      (mlen_ff <= MLW'(MASK_CHARS)) && (nlen_ff <= NLW'(NAME_CHARS)))
      else $error("string length beyond buffer size");

endmodule

@@ tb/testbench.sv @@
// self-checking testbench for the wildcard mask matcher: directed table, then random mask/name pairs
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   import wmm_pkg::*;

   localparam int  MASK_CHARS   = 64;
   localparam int  NAME_CHARS   = 64;
   localparam int  CLK_PERIOD   = 10;
   localparam int  RESET_CYCLES = 8;
   localparam int  IDLE_PCT     = 22;
   localparam int  RANDOM_ITEMS = 850;
   localparam int  CALM_FROM    = 300;   // random beats in this window run with no idling
   localparam int  CALM_TO      = 420;
   localparam int  PAUSE_AT     = 550;   // sender drains all results once around here
   localparam int  DRAIN_CYCLES = 40;
   // a full 64 by 64 backtracking walk with a stalled receiver stays far below this
   localparam int  STALL_LIMIT  = 200000;
   localparam int  REPORT_MAX   = 10;
   localparam int  OVF_LEN      = 68;    // random length bound, 4 bytes past the buffer

   // which string a beat belongs to
   localparam logic OP_MASK = 1'b0;
   localparam logic OP_NAME = 1'b1;

   // where the expected result of a name end comes from
   typedef enum logic { SRC_PREDICT, SRC_FIXED } result_src_type;

   typedef struct packed {
      logic       operation;
      logic [7:0] char_code;
      logic       empty_req;
      logic       last;
   } beat_type;

   typedef struct packed {
      logic matched;
      logic overflow;
   } match_result_type;

   typedef struct packed {
      logic           operation;
      logic [7:0]     char_code;
      logic           empty_req;
      logic           last;
      result_src_type src;
      logic           fixed_matched;
      logic           fixed_overflow;
   } dir_row_type;

   localparam int DIR_ROWS = 29;

   // directed beats; fixed expectations only where the answer is plain
   dir_row_type directed_rows [DIR_ROWS] = '{
      // empty mask against empty name: match (char ignored on empty beats)
      '{OP_MASK, 8'h00,     1'b1, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, 8'hA5,     1'b1, 1'b1, SRC_FIXED,   1'b1, 1'b0},
      // empty mask against a one-letter name: no match
      '{OP_MASK, 8'hFF,     1'b1, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "a",       1'b0, 1'b1, SRC_FIXED,   1'b0, 1'b0},
      // lone star against an empty name: match
      '{OP_MASK, CH_STAR,   1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, 8'h00,     1'b1, 1'b1, SRC_FIXED,   1'b1, 1'b0},
      // case folding and a single-character wildcard
      '{OP_MASK, "A",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, CH_QUEST,  1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "a",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "b",       1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      // escaped star is a literal star
      '{OP_MASK, CH_BSLASH, 1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, CH_STAR,   1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, CH_STAR,   1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      // question-mark run after an inner star with name left over
      '{OP_MASK, "a",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, CH_STAR,   1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, CH_QUEST,  1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "a",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "b",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "c",       1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      // top byte, then a stored zero byte that ends the mask early
      '{OP_MASK, 8'hFF,     1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, 8'h00,     1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, 8'hFF,     1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      // high bytes are not case folded
      '{OP_MASK, 8'hC1,     1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, 8'hE1,     1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      // mask keeps growing after its last beat, empty filler in between
      '{OP_MASK, "x",       1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, 8'h5A,     1'b1, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_MASK, CH_QUEST,  1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "X",       1'b0, 1'b0, SRC_PREDICT, 1'b0, 1'b0},
      '{OP_NAME, "y",       1'b0, 1'b1, SRC_PREDICT, 1'b0, 1'b0}
   };

   logic clock = 1'b0;
   logic reset;

   wmm_req_if req_bus ();
   wmm_rsp_if rsp_bus ();

   wildcard_mask_matcher #(
      .MASK_CHARS (MASK_CHARS),
      .NAME_CHARS (NAME_CHARS)
   ) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_bus),
      .rsp_if (rsp_bus)
   );

   always #(CLK_PERIOD / 2) clock = ~clock;

   // shadow copy of the block's string buffers
   logic [7:0]    mask_buf [MASK_CHARS];
   logic [7:0]    name_buf [NAME_CHARS];
   int            mask_len;
   int            name_len;
   logic          ovf_seen;

   match_result_type expected_results [$];
   int               mismatches;
   int               items_sent;
   int               idle_cycles;
   logic             calm;

   // reading at or past the stored length gives the terminating zero
   function automatic logic [7:0] mask_at(input int p);
      return (p >= 0 && p < mask_len) ? mask_buf[p] : CH_NUL;
   endfunction

   function automatic logic [7:0] name_at(input int p);
      return (p >= 0 && p < name_len) ? name_buf[p] : CH_NUL;
   endfunction

   function automatic logic [7:0] to_lower(input logic [7:0] c);
      return (c >= CH_UPPER_A && c <= CH_UPPER_Z) ? (c | CASE_OFFSET) : c;
   endfunction

   // backtracking glob walk over the shadow buffers, 1 on a match
   function automatic logic glob_walk();
      int         m = 0;
      int         n = 0;
      int         m_retry = 0;
      int         n_retry = 0;
      logic       wild = 1'b0;
      logic       lit;
      logic [7:0] c;
      forever begin
         if (mask_at(m) == CH_STAR) begin
            while (mask_at(m) == CH_STAR) m++;
            wild    = 1'b1;
            m_retry = m;
            n_retry = n;
         end
         if (mask_at(m) == CH_NUL) begin
            if (name_at(n) == CH_NUL) return 1'b1;
            if (m == 0) return 1'b0;
            // step back over a trailing run of question marks
            m--;
            while (m > 0 && mask_at(m) == CH_QUEST) m--;
            if (mask_at(m) == CH_STAR && m > 0 && mask_at(m - 1) != CH_BSLASH) return 1'b1;
            if (!wild) return 1'b0;
            m = m_retry;
            n_retry++;
            n = n_retry;
         end else if (name_at(n) == CH_NUL) begin
            while (mask_at(m) == CH_STAR) m++;
            return mask_at(m) == CH_NUL;
         end
         lit = 1'b0;
         if (mask_at(m) == CH_BSLASH &&
             (mask_at(m + 1) == CH_STAR || mask_at(m + 1) == CH_QUEST)) begin
            m++;
            lit = 1'b1;
         end
         c = mask_at(m);
         if (to_lower(c) != to_lower(name_at(n)) && (c != CH_QUEST || lit)) begin
            if (!wild) return 1'b0;
            m = m_retry;
            n_retry++;
            n = n_retry;
         end else begin
            if (c != CH_NUL) m++;
            if (name_at(n) != CH_NUL) n++;
         end
      end
   endfunction

   // fold one accepted beat into the shadow state, queue a result on a name end
   function automatic void take_beat(input beat_type b, input result_src_type src,
                                     input logic fm, input logic fo);
      match_result_type r;
      if (!b.empty_req) begin
         if (b.operation == OP_NAME) begin
            if (name_len < NAME_CHARS) begin
               name_buf[name_len] = b.char_code;
               name_len++;
            end else begin
               ovf_seen = 1'b1;
            end
         end else begin
            if (mask_len < MASK_CHARS) begin
               mask_buf[mask_len] = b.char_code;
               mask_len++;
            end else begin
               ovf_seen = 1'b1;
            end
         end
      end
      if (b.operation == OP_NAME && b.last) begin
         r.overflow = ovf_seen;
         r.matched  = ovf_seen ? 1'b0 : glob_walk();
         if (src == SRC_FIXED) begin
            r.matched  = fm;
            r.overflow = fo;
         end
         expected_results.push_back(r);
         mask_len = 0;
         name_len = 0;
         ovf_seen = 1'b0;
      end
   endfunction

   function automatic beat_type mk_beat(input logic op, input logic [7:0] ch,
                                        input logic empty, input logic last);
      beat_type b;
      b.operation = op;
      b.char_code = ch;
      b.empty_req = empty;
      b.last      = last;
      return b;
   endfunction

   // mostly short strings, now and then long ones, rarely past the buffer
   function automatic int pick_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 80) return $urandom_range(0, 8);
      if (r < 95) return $urandom_range(9, 40);
      if (r < 98) return $urandom_range(41, 64);
      return $urandom_range(65, OVF_LEN - 1);
   endfunction

   function automatic logic [7:0] name_letter();
      if ($urandom_range(0, 1) != 0) return 8'("a" + $urandom_range(0, 2));
      return 8'("A" + $urandom_range(0, 2));
   endfunction

   function automatic logic [7:0] mask_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return name_letter();
      if (r < 65) return CH_STAR;
      if (r < 80) return CH_QUEST;
      if (r < 88) return CH_BSLASH;
      if (r < 98) return 8'($urandom_range(0, 255));
      return CH_NUL;
   endfunction

   function automatic logic [7:0] name_char();
      int r;
      r = $urandom_range(0, 99);
      if (r < 85) return name_letter();
      if (r < 90) return CH_STAR;
      if (r < 95) return CH_QUEST;
      return 8'($urandom_range(0, 255));
   endfunction

   // one beat on the request channel; payload changes only at the falling edge
   task automatic send_beat(input beat_type b, input result_src_type src,
                            input logic fm, input logic fo);
      while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
         req_bus.valid = 1'b0;
         @(negedge clock);
      end
      req_bus.valid     = 1'b1;
      req_bus.operation = b.operation;
      req_bus.char_code = b.char_code;
      req_bus.empty_req = b.empty_req;
      req_bus.last      = b.last;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      take_beat(b, src, fm, fo);
      // beats that change nothing do not count toward the total
      if (!b.empty_req || (b.operation == OP_NAME && b.last)) items_sent++;
      @(negedge clock);
   endtask

   // hold the sender off until every queued result has come back
   task automatic drain_results();
      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(negedge clock);
   endtask

   // one random mask and name; most are well formed, some interleaved or cut short
   task automatic send_pair();
      logic [7:0] mask_q [$];
      logic [7:0] name_q [$];
      logic [7:0] c;
      int         len;
      int         i;
      int         mi;
      int         ni;
      logic       sep_end;
      len = pick_len();
      repeat (len) mask_q.push_back(mask_char());
      if ($urandom_range(0, 99) < 60) begin
         // name grown from the mask so that matches are common
         i = 0;
         while (i < mask_q.size() && name_q.size() < OVF_LEN) begin
            c = mask_q[i];
            if (c == CH_BSLASH && i + 1 < mask_q.size() &&
                (mask_q[i + 1] == CH_STAR || mask_q[i + 1] == CH_QUEST)) begin
               name_q.push_back(mask_q[i + 1]);
               i += 2;
            end else if (c == CH_STAR) begin
               repeat ($urandom_range(0, 3)) name_q.push_back(name_letter());
               i++;
            end else if (c == CH_QUEST) begin
               name_q.push_back(name_letter());
               i++;
            end else begin
               if (((c >= CH_UPPER_A && c <= CH_UPPER_Z) || (c >= "a" && c <= "z")) &&
                   $urandom_range(0, 1) != 0) begin
                  c = c ^ CASE_OFFSET;
               end
               name_q.push_back(c);
               i++;
            end
         end
         // near misses
         if ($urandom_range(0, 99) < 15) name_q.push_back(name_letter());
      end else begin
         len = pick_len();
         repeat (len) name_q.push_back(name_char());
      end

      if ($urandom_range(0, 99) < 85) begin
         if (mask_q.size() == 0) begin
            send_beat(mk_beat(OP_MASK, 8'($urandom_range(0, 255)), 1'b1, 1'b1),
                      SRC_PREDICT, 1'b0, 1'b0);
         end
         foreach (mask_q[k]) begin
            send_beat(mk_beat(OP_MASK, mask_q[k], 1'b0, k == mask_q.size() - 1),
                      SRC_PREDICT, 1'b0, 1'b0);
         end
         sep_end = (name_q.size() == 0) || ($urandom_range(0, 4) == 0);
         foreach (name_q[k]) begin
            send_beat(mk_beat(OP_NAME, name_q[k], 1'b0, !sep_end && k == name_q.size() - 1),
                      SRC_PREDICT, 1'b0, 1'b0);
         end
         if (sep_end) begin
            send_beat(mk_beat(OP_NAME, 8'($urandom_range(0, 255)), 1'b1, 1'b1),
                      SRC_PREDICT, 1'b0, 1'b0);
         end
      end else begin
         // mask and name bytes interleaved, stray flags and empty filler beats
         mi = 0;
         ni = 0;
         while (mi < mask_q.size() || ni < name_q.size()) begin
            if ($urandom_range(0, 9) == 0) begin
               send_beat(mk_beat(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                                 1'b1, 1'b0), SRC_PREDICT, 1'b0, 1'b0);
            end
            if (ni >= name_q.size() || (mi < mask_q.size() && $urandom_range(0, 1) != 0)) begin
               send_beat(mk_beat(OP_MASK, mask_q[mi], 1'b0, 1'($urandom_range(0, 1))),
                         SRC_PREDICT, 1'b0, 1'b0);
               mi++;
            end else begin
               send_beat(mk_beat(OP_NAME, name_q[ni], 1'b0, 1'b0), SRC_PREDICT, 1'b0, 1'b0);
               ni++;
            end
         end
         // now and then no name end at all: the strings carry into the next pair
         if ($urandom_range(0, 9) != 0) begin
            send_beat(mk_beat(OP_NAME, 8'($urandom_range(0, 255)), 1'b1, 1'b1),
                      SRC_PREDICT, 1'b0, 1'b0);
         end
      end
   endtask

   function automatic void report_mismatch(input string what, input match_result_type want,
                                           input match_result_type got);
      if (mismatches < REPORT_MAX) begin
         $display("%0t: %s: expected matched=%0b overflow=%0b, got matched=%0b overflow=%0b",
                  $realtime, what, want.matched, want.overflow, got.matched, got.overflow);
      end
      mismatches++;
   endfunction

   // receiver stalls, sampled by the block at the next rising edge
   always @(negedge clock) begin
      rsp_bus.ready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
   end

   // result check at the rising edge, oldest expectation first
   always @(posedge clock) begin
      match_result_type want;
      match_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got.matched  = rsp_bus.matched;
         got.overflow = rsp_bus.overflow;
         if (expected_results.size() == 0) begin
            want = '0;
            report_mismatch("result with nothing pending", want, got);
         end else begin
            want = expected_results.pop_front();
            if (got.matched !== want.matched || got.overflow !== want.overflow) begin
               report_mismatch("result mismatch", want, got);
            end
         end
      end
   end

   // watchdog: too long without a beat on either channel
   always @(posedge clock) begin
      if (reset || (req_bus.valid && req_bus.ready) || (rsp_bus.valid && rsp_bus.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= STALL_LIMIT) begin
         $display("%0t: no beat for %0d cycles", $realtime, STALL_LIMIT);
         $display("RESULT: ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      logic paused;
      // every input known from time zero
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_MASK;
      req_bus.char_code = 8'h00;
      req_bus.empty_req = 1'b0;
      req_bus.last      = 1'b0;
      rsp_bus.ready     = 1'b0;
      mask_len          = 0;
      name_len          = 0;
      ovf_seen          = 1'b0;
      mismatches        = 0;
      items_sent        = 0;
      idle_cycles       = 0;
      calm              = 1'b0;
      paused            = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (directed_rows[r]) begin
         send_beat(mk_beat(directed_rows[r].operation, directed_rows[r].char_code,
                           directed_rows[r].empty_req, directed_rows[r].last),
                   directed_rows[r].src, directed_rows[r].fixed_matched,
                   directed_rows[r].fixed_overflow);
      end
      drain_results();

      // random pairs, with one window of full throughput on both sides
      items_sent = 0;
      while (items_sent < RANDOM_ITEMS) begin
         calm = (items_sent >= CALM_FROM && items_sent < CALM_TO);
         if (!paused && items_sent >= PAUSE_AT) begin
            paused = 1'b1;
            drain_results();
         end
         send_pair();
      end
      calm = 1'b0;

      req_bus.valid = 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatches == 0 && expected_results.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
